[hdl/prd_pkg.sv]
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types, codes and constants of the palette RLE sprite decoder.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
  localparam int unsigned LEN_W           = 12;
  localparam int unsigned CFG_DATA_W      = 12;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CODE_ESCAPE        = 8'd255;
  localparam logic [7:0] SHADOW_RUN_CODE    = 8'd250;
  localparam logic [7:0] ALPHA_OPAQUE       = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR        = 8'd0;
  localparam logic [11:0] LINE_WIDTH_RESET  = 12'd64;

  // Configuration register indexes
  localparam logic CFG_SHADOW_ENABLE = 1'b0;
  localparam logic CFG_LINE_WIDTH    = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_RUN    = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e              op;
    logic [PAL_IDX_W-1:0] index;
    logic [15:0]          color;
    logic [7:0]           alpha;
    logic [LEN_W-1:0]     run_length;
    logic                 done;
  } cmd_t;

  // Alpha of a shadow pixel by its offset from the shadow start code;
  // offset zero is the shadow run.
  function automatic logic [7:0] shade_alpha(input logic [2:0] offset);
    logic [7:0] a;
    case (offset)
      3'd0:    a = 8'(255 - 152);
      3'd1:    a = 8'(255 - 216);
      3'd2:    a = 8'(255 - 228);
      3'd3:    a = 8'(255 - 240);
      3'd4:    a = 8'(255 - 248);
      default: a = ALPHA_CLEAR;
    endcase
    return a;
  endfunction

endpackage

[hdl/prd_ifs.sv]
// ----------------------------------------------------------------------------
// prd_ifs
// Valid/ready channels for encoded input items and decoded pixel runs.
// ----------------------------------------------------------------------------
interface prd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  byte_value;
  logic [7:0]  palette_index;
  logic [15:0] palette_color;
  logic        end_of_image;

  modport source (output valid, kind, byte_value, palette_index, palette_color,
                  end_of_image, input ready);
  modport sink   (input valid, kind, byte_value, palette_index, palette_color,
                  end_of_image, output ready);
endinterface

interface prd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [11:0] run_length;
  logic        image_done;

  modport source (output valid, red, green, blue, alpha, run_length, image_done,
                  input ready);
  modport sink   (input valid, red, green, blue, alpha, run_length, image_done,
                  output ready);
endinterface

[hdl/prd_front.sv]
// ----------------------------------------------------------------------------
// prd_front
// Accepts input transactions, tracks escapes and issues back-end commands.
// ----------------------------------------------------------------------------
module prd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [prd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  prd_in_if.sink                       in_if,
  input  logic                         q_full_i,
  output logic                         push_o,
  output prd_pkg::cmd_t                cmd_o
);

  logic        shadow_en_q;
  logic [11:0] line_width_q;
  logic        pending_q, pending_d;
  logic        is_shadow_q, is_shadow_d;
  logic        accept;
  logic        emit;

  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && !q_full_i;
  assign push_o      = accept && emit;

  always_comb begin
    logic [11:0] len;
    pending_d   = pending_q;
    is_shadow_d = is_shadow_q;
    emit        = 1'b0;
    len         = 12'd1;
    cmd_o.op         = prd_pkg::OP_LOOKUP;
    cmd_o.index      = in_if.byte_value;
    cmd_o.color      = in_if.palette_color;
    cmd_o.alpha      = prd_pkg::ALPHA_OPAQUE;
    cmd_o.run_length = 12'd1;
    cmd_o.done       = in_if.end_of_image;
    if (in_if.kind) begin
      // palette load: no result, escape state untouched
      emit        = 1'b1;
      cmd_o.op    = prd_pkg::OP_WRITE;
      cmd_o.index = in_if.palette_index;
    end else if (pending_q) begin
      pending_d   = 1'b0;
      is_shadow_d = 1'b0;
      if (is_shadow_q) begin
        len         = {4'd0, in_if.byte_value};
        cmd_o.alpha = prd_pkg::shade_alpha(3'd0);
      end else begin
        len         = (in_if.byte_value == prd_pkg::CODE_ESCAPE) ? line_width_q
                                                                 : {4'd0, in_if.byte_value};
        cmd_o.alpha = prd_pkg::ALPHA_CLEAR;
      end
      cmd_o.op         = prd_pkg::OP_RUN;
      cmd_o.run_length = len;
      emit             = (len != 12'd0);
    end else if (in_if.byte_value == prd_pkg::CODE_ESCAPE ||
                 (shadow_en_q && in_if.byte_value == prd_pkg::SHADOW_RUN_CODE)) begin
      // drop an escape left open at end of image
      pending_d   = !in_if.end_of_image;
      is_shadow_d = !in_if.end_of_image && (in_if.byte_value != prd_pkg::CODE_ESCAPE);
    end else if (shadow_en_q && (in_if.byte_value inside {[8'd251:8'd254]})) begin
      emit        = 1'b1;
      cmd_o.op    = prd_pkg::OP_RUN;
      cmd_o.alpha = prd_pkg::shade_alpha(3'(in_if.byte_value - prd_pkg::SHADOW_RUN_CODE));
    end else begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_en_q  <= 1'b0;
      line_width_q <= prd_pkg::LINE_WIDTH_RESET;
      pending_q    <= 1'b0;
      is_shadow_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          prd_pkg::CFG_SHADOW_ENABLE: shadow_en_q  <= cfg_data_i[0];
          prd_pkg::CFG_LINE_WIDTH:    line_width_q <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (accept) begin
        pending_q   <= pending_d;
        is_shadow_q <= is_shadow_d;
      end
    end
  end

endmodule

[hdl/prd_queue.sv]
// ----------------------------------------------------------------------------
// prd_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module prd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  prd_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output prd_pkg::cmd_t data_o
);

  prd_pkg::cmd_t                  slots_q [prd_pkg::QUEUE_DEPTH];
  logic [prd_pkg::QPTR_W-1:0]     wr_ptr_q;
  logic [prd_pkg::QPTR_W-1:0]     rd_ptr_q;
  logic [prd_pkg::QCNT_W-1:0]     count_q;

  assign full_o  = (count_q == prd_pkg::QCNT_W'(prd_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[hdl/prd_back.sv]
// ----------------------------------------------------------------------------
// prd_back
// Executes commands: palette loads, palette reads and run output.
// ----------------------------------------------------------------------------
module prd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  prd_pkg::cmd_t q_data_i,
  output logic          pop_o,
  prd_out_if.source     out_if
);

  logic [15:0] palette_mem [prd_pkg::PALETTE_ENTRIES];
  logic [15:0] rd_data_q;
  logic        s1_valid_q;
  logic        s1_lookup_q;
  logic [7:0]  s1_alpha_q;
  logic [11:0] s1_len_q;
  logic        s1_done_q;
  logic        out_valid_q;
  logic [7:0]  red_q, green_q, blue_q, alpha_q;
  logic [11:0] len_q;
  logic        done_q;
  logic        s1_adv;
  logic        s1_free;

  assign s1_adv  = s1_valid_q && (!out_valid_q || out_if.ready);
  assign s1_free = !s1_valid_q || s1_adv;
  assign pop_o   = q_valid_i && s1_free;

  // palette port: write on a load, registered read on every pop
  always_ff @(posedge clk_i) begin
    if (pop_o && q_data_i.op == prd_pkg::OP_WRITE) begin
      palette_mem[q_data_i.index] <= q_data_i.color;
    end
    if (pop_o) begin
      rd_data_q <= palette_mem[q_data_i.index];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_lookup_q <= (q_data_i.op == prd_pkg::OP_LOOKUP);
      s1_alpha_q  <= q_data_i.alpha;
      s1_len_q    <= q_data_i.run_length;
      s1_done_q   <= q_data_i.done;
    end
    if (s1_adv) begin
      if (s1_lookup_q) begin
        red_q   <= {rd_data_q[15:11], 3'b000};
        green_q <= {rd_data_q[10:5], 2'b00};
        blue_q  <= {rd_data_q[4:0], 3'b000};
      end else begin
        red_q   <= 8'd0;
        green_q <= 8'd0;
        blue_q  <= 8'd0;
      end
      alpha_q <= s1_alpha_q;
      len_q   <= s1_len_q;
      done_q  <= s1_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) s1_valid_q <= pop_o && (q_data_i.op != prd_pkg::OP_WRITE);
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.red        = red_q;
  assign out_if.green      = green_q;
  assign out_if.blue       = blue_q;
  assign out_if.alpha      = alpha_q;
  assign out_if.run_length = len_q;
  assign out_if.image_done = done_q;

endmodule

[hdl/palette_rle_sprite_decoder_unit.sv]
// ----------------------------------------------------------------------------
// palette_rle_sprite_decoder_unit
// Palette run-length sprite decoder: encoded bytes in, RGBA pixel runs out.
// ----------------------------------------------------------------------------
// The unit takes one input transaction per clock while the command queue is
// not full, and delivers at most one pixel run per transaction, in order. A
// run passes through the command queue, the palette read register and the
// output register before it is presented. A front end classifies each byte
// (escape, shadow, palette color, palette load) and tracks the open escape; a
// four-entry command queue lets it run ahead of the back end, which owns the
// 256 x 16 palette RAM (a write on a load, a registered read on each pop)
// and the output register. Palette loads travel through the queue, so a color
// read always sees exactly the loads that came before it in the stream.
// Throughput is one transaction per cycle when the output is not stalled, set
// by the single palette port and the queue pop. Registers (write only): index
// 0 shadow_enable, index 1 line_width; change them only while the unit is
// idle. Reading a palette entry that was never loaded returns undefined color.
// ----------------------------------------------------------------------------
module palette_rle_sprite_decoder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [prd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  prd_in_if.sink                         in_if,
  prd_out_if.source                      out_if
);

  logic          q_full;
  logic          push;
  prd_pkg::cmd_t push_cmd;
  logic          q_valid;
  prd_pkg::cmd_t q_cmd;
  logic          pop;

  // Front: accept transactions, resolve escapes, issue commands
  prd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_if       (in_if),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Decouple front and back so either side may stall alone
  prd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_cmd)
  );

  // Back: palette RAM access and run output register
  prd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_cmd),
    .pop_o     (pop),
    .out_if    (out_if)
  );

endmodule

[hdl/prd_checker.sv]
// ----------------------------------------------------------------------------
// prd_checker
// Port-level checks of the decoder's result stream.
// ----------------------------------------------------------------------------
module prd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  red_i,
  input logic [7:0]  green_i,
  input logic [7:0]  blue_i,
  input logic [7:0]  alpha_i,
  input logic [11:0] run_length_i,
  input logic        image_done_i
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable({red_i, green_i, blue_i,
                                                           alpha_i, run_length_i,
                                                           image_done_i}))
    else $error("stalled result changed");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> run_length_i != 12'd0)
    else $error("zero-length run delivered");

  // Transparent and shadow runs are black
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alpha_i != 8'd255 |-> red_i == 8'd0 && green_i == 8'd0 &&
                                         blue_i == 8'd0)
    else $error("non-opaque run has color");

  // Palette pixels are single and carry expanded 565 color
  a_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alpha_i == 8'd255 |-> run_length_i == 12'd1 && red_i[2:0] == 3'd0 &&
                                         green_i[1:0] == 2'd0 && blue_i[2:0] == 3'd0)
    else $error("palette pixel malformed");

endmodule

bind palette_rle_sprite_decoder_unit prd_checker u_prd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .red_i        (out_if.red),
  .green_i      (out_if.green),
  .blue_i       (out_if.blue),
  .alpha_i      (out_if.alpha),
  .run_length_i (out_if.run_length),
  .image_done_i (out_if.image_done)
);

[dv/prd_run_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_tb_pkg
// Item and run types plus the run tracker of the sprite decoder testbench.
// The tracker keeps its own palette, register copies and escape state. It
// works out the run that each accepted transaction should produce and
// checks the decoded runs against them in order.
// ----------------------------------------------------------------------------
package prd_tb_pkg;
  import prd_pkg::*;

  typedef enum logic {
    ITEM_STREAM  = 1'b0,
    ITEM_PALETTE = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  byte_value;
    logic [7:0]  palette_index;
    logic [15:0] palette_color;
    logic        end_of_image;
  } sprite_item_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [LEN_W-1:0] run_length;
    logic             image_done;
  } pixel_run_t;

  localparam logic [7:0] SHADOW_LAST_CODE = 8'd254;
  // Offset zero is the shadow run, offsets one to four the single pixels.
  localparam logic [7:0] SHADE_ALPHA [0:4] = '{8'd103, 8'd39, 8'd27, 8'd15, 8'd7};

  class pixel_run_tracker;
    logic [15:0]      palette [PALETTE_ENTRIES];
    bit               shadow_on;
    logic [LEN_W-1:0] blank_len;
    bit               esc_open;
    bit               esc_shadow;
    pixel_run_t       runs_due [$];
    int               mismatch_count;

    function new();
      shadow_on      = 1'b0;
      blank_len      = LINE_WIDTH_RESET;
      esc_open       = 1'b0;
      esc_shadow     = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_register(input logic idx, input logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_SHADOW_ENABLE) shadow_on = val[0];
      else blank_len = val[LEN_W-1:0];
    endfunction

    function int pending();
      return runs_due.size();
    endfunction

    // Work out the run of one accepted transaction, if it makes one.
    function void note_item(input sprite_item_t it);
      pixel_run_t       run;
      logic [15:0]      c;
      logic [LEN_W-1:0] len;
      bit               emit;
      emit = 1'b0;
      run  = '0;
      if (it.kind == ITEM_PALETTE) begin
        palette[it.palette_index] = it.palette_color;
        return;
      end
      if (esc_open) begin
        // count byte: the escape kind was fixed when the escape arrived
        esc_open = 1'b0;
        if (esc_shadow) begin
          len       = LEN_W'(it.byte_value);
          run.alpha = SHADE_ALPHA[0];
        end else begin
          len       = (it.byte_value == CODE_ESCAPE) ? blank_len : LEN_W'(it.byte_value);
          run.alpha = ALPHA_CLEAR;
        end
        esc_shadow = 1'b0;
        if (len != '0) begin
          run.run_length = len;
          emit           = 1'b1;
        end
      end else if (it.byte_value == CODE_ESCAPE ||
                   (shadow_on && it.byte_value == SHADOW_RUN_CODE)) begin
        // an escape on the last byte of an image is dropped
        esc_open   = !it.end_of_image;
        esc_shadow = !it.end_of_image && (it.byte_value != CODE_ESCAPE);
      end else if (shadow_on && it.byte_value > SHADOW_RUN_CODE &&
                   it.byte_value <= SHADOW_LAST_CODE) begin
        run.alpha      = SHADE_ALPHA[it.byte_value - SHADOW_RUN_CODE];
        run.run_length = LEN_W'(1);
        emit           = 1'b1;
      end else begin
        c              = palette[it.byte_value];
        run.red        = {c[15:11], 3'b000};
        run.green      = {c[10:5], 2'b00};
        run.blue       = {c[4:0], 3'b000};
        run.alpha      = ALPHA_OPAQUE;
        run.run_length = LEN_W'(1);
        emit           = 1'b1;
      end
      if (emit) begin
        run.image_done = it.end_of_image;
        runs_due.push_back(run);
      end
    endfunction

    function void compare_field(input string name, input logic [11:0] want,
                                input logic [11:0] got);
      if (got !== want) begin
        $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_run(input pixel_run_t got);
      pixel_run_t want;
      if (runs_due.size() == 0) begin
        $display("%0t: unexpected run: expected none, actual rgba %0d %0d %0d %0d len %0d",
                 $time, got.red, got.green, got.blue, got.alpha, got.run_length);
        mismatch_count++;
        return;
      end
      want = runs_due.pop_front();
      compare_field("red", 12'(want.red), 12'(got.red));
      compare_field("green", 12'(want.green), 12'(got.green));
      compare_field("blue", 12'(want.blue), 12'(got.blue));
      compare_field("alpha", 12'(want.alpha), 12'(got.alpha));
      compare_field("run_length", want.run_length, got.run_length);
      compare_field("image_done", 12'(want.image_done), 12'(got.image_done));
    endfunction
  endclass

endpackage

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and checking for the palette RLE sprite decoder unit.
// A directed part walks the escape codes, shadow codes, zero-length runs,
// escapes dropped at end of image and register changes with an escape open.
// Random phases then mix palette loads with mostly well-formed escape
// sequences under several register settings and handshake idle patterns.
// Every decoded run is checked in order against the run tracker.
// ----------------------------------------------------------------------------
module testbench;
  import prd_pkg::*;
  import prd_tb_pkg::*;

  localparam int SETTLE_CYCLES = 12;     // output latency plus margin
  localparam int PHASE_ITEMS   = 260;
  localparam int HOLD_CYCLES   = 120;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Percentages of cycles in which the sender idles / the receiver stalls.
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  // Request for a long receiver hold-off, picked up by the receiver process.
  int          hold_request;

  pixel_run_tracker runs = new();

  prd_in_if  byte_ch ();
  prd_out_if run_ch ();

  palette_rle_sprite_decoder_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_if       (byte_ch),
    .out_if      (run_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard limit on the run: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one transaction, with random idle cycles first, and hold it until
  // it is accepted. Valid stays high when the next call sends back to back.
  task automatic send(input sprite_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.kind          <= it.kind;
    byte_ch.byte_value    <= it.byte_value;
    byte_ch.palette_index <= it.palette_index;
    byte_ch.palette_color <= it.palette_color;
    byte_ch.end_of_image  <= it.end_of_image;
    @(posedge clk);
    while (byte_ch.ready !== 1'b1) @(posedge clk);
    runs.note_item(it);
  endtask

  // Stream byte; the palette fields are don't-care, so fill them at random.
  task automatic stream(input logic [7:0] code, input logic eoi);
    sprite_item_t it;
    it.kind          = ITEM_STREAM;
    it.byte_value    = code;
    it.palette_index = 8'($urandom);
    it.palette_color = 16'($urandom);
    it.end_of_image  = eoi;
    send(it);
  endtask

  // Palette load; byte and end-of-image are ignored by the block.
  task automatic load_entry(input logic [7:0] idx, input logic [15:0] color);
    sprite_item_t it;
    it.kind          = ITEM_PALETTE;
    it.byte_value    = 8'($urandom);
    it.palette_index = idx;
    it.palette_color = color;
    it.end_of_image  = 1'($urandom);
    send(it);
  endtask

  // Drop valid, wait until every expected run is out, then let the pipe
  // settle so that no transaction without a run is still in flight.
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    while (runs.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    runs.set_register(idx, val);
    @(posedge clk);
  endtask

  // Run byte for an escape: lean on the blank-line code and on zero.
  function automatic logic [7:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(11);
    if (roll < 2) return CODE_ESCAPE;
    if (roll == 2) return 8'd0;
    return 8'($urandom_range(254, 1));
  endfunction

  // One random sequence: mostly well-formed escapes and colors, some noise
  // that may break an escape apart.
  task automatic random_sequence();
    int unsigned pick;
    logic        eoi;
    pick = $urandom_range(99);
    eoi  = ($urandom_range(19) == 0);
    if (pick < 8) begin
      load_entry(8'($urandom), 16'($urandom));
    end else if (pick < 50) begin
      stream(8'($urandom_range(249)), eoi);
    end else if (pick < 65) begin
      stream(CODE_ESCAPE, 1'b0);
      stream(pick_count(), eoi);
    end else if (pick < 75) begin
      stream(SHADOW_RUN_CODE, 1'b0);
      stream(pick_count(), eoi);
    end else if (pick < 85) begin
      stream(8'($urandom_range(254, 251)), eoi);
    end else begin
      stream(8'($urandom), eoi);
    end
  endtask

  // Receiver: check each accepted run, then choose ready for the next cycle.
  // A hold-off request keeps ready low for a counted stretch.
  initial begin
    int         hold_left;
    pixel_run_t got;
    hold_left = 0;
    run_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run_ch.valid === 1'b1 && run_ch.ready === 1'b1) begin
        got.red        = run_ch.red;
        got.green      = run_ch.green;
        got.blue       = run_ch.blue;
        got.alpha      = run_ch.alpha;
        got.run_length = run_ch.run_length;
        got.image_done = run_ch.image_done;
        runs.check_run(got);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        run_ch.ready <= 1'b0;
      end else begin
        run_ch.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  initial begin
    int unsigned      idle_in  [4];
    int unsigned      stall_out[4];
    bit               shadow_cfg[4];
    logic [LEN_W-1:0] width_cfg[4];

    idle_in    = '{0, 79, 0, 21};
    stall_out  = '{0, 0, 79, 21};
    shadow_cfg = '{1'b1, 1'b0, 1'b1, 1'b0};
    width_cfg  = '{12'd1, 12'd4095, 12'($urandom_range(4095, 1)),
                   12'($urandom_range(300, 2))};

    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_request  = 0;

    // Hold every input at a known value from time zero.
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_SHADOW_ENABLE;
    cfg_data              <= '0;
    byte_ch.valid         <= 1'b0;
    byte_ch.kind          <= ITEM_STREAM;
    byte_ch.byte_value    <= '0;
    byte_ch.palette_index <= '0;
    byte_ch.palette_color <= '0;
    byte_ch.end_of_image  <= 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values: shadowing off, line width 64.
    load_entry(8'd0, 16'h0000);
    load_entry(8'd255, 16'hFFFF);
    load_entry(8'd250, 16'hF800);
    load_entry(8'd251, 16'h07E0);
    load_entry(8'd254, 16'h001F);
    // shadow codes read the palette while shadowing is off
    stream(8'd0, 1'b0);
    stream(8'd250, 1'b0);
    stream(8'd251, 1'b0);
    stream(8'd254, 1'b0);
    stream(CODE_ESCAPE, 1'b0);
    stream(8'd5, 1'b0);
    // blank line at the reset width
    stream(CODE_ESCAPE, 1'b0);
    stream(CODE_ESCAPE, 1'b0);
    // zero-length transparent run gives nothing
    stream(CODE_ESCAPE, 1'b0);
    stream(8'd0, 1'b0);
    // escape on the last byte of an image is dropped
    stream(CODE_ESCAPE, 1'b1);
    // a palette load in the middle of an escape leaves it open
    stream(CODE_ESCAPE, 1'b0);
    load_entry(8'd128, 16'hFFFF);
    stream(8'd254, 1'b1);
    // leave a transparent escape open across the register change
    stream(CODE_ESCAPE, 1'b0);
    wait_idle();
    cfg_write(CFG_SHADOW_ENABLE, 12'd1);
    cfg_write(CFG_LINE_WIDTH, 12'd4095);
    stream(CODE_ESCAPE, 1'b0);
    // shadow runs: zero count, and 255 as a plain count
    stream(SHADOW_RUN_CODE, 1'b0);
    stream(8'd0, 1'b0);
    stream(SHADOW_RUN_CODE, 1'b0);
    stream(CODE_ESCAPE, 1'b0);
    stream(8'd251, 1'b0);
    stream(8'd252, 1'b0);
    stream(8'd253, 1'b0);
    stream(8'd254, 1'b1);
    stream(SHADOW_RUN_CODE, 1'b1);
    // leave a shadow escape open while shadowing is switched off
    stream(SHADOW_RUN_CODE, 1'b0);
    wait_idle();
    cfg_write(CFG_SHADOW_ENABLE, 12'd0);
    cfg_write(CFG_LINE_WIDTH, 12'd1);
    stream(8'd3, 1'b0);
    stream(CODE_ESCAPE, 1'b0);
    stream(CODE_ESCAPE, 1'b1);

    // Random phases.
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      cfg_write(CFG_SHADOW_ENABLE, 12'(shadow_cfg[ph]));
      cfg_write(CFG_LINE_WIDTH, width_cfg[ph]);
      in_idle_pct   = idle_in[ph];
      out_stall_pct = stall_out[ph];
      if (ph == 0) begin
        // fill the whole palette so any byte can be decoded from here on
        for (int i = 0; i < PALETTE_ENTRIES; i++) load_entry(8'(i), 16'($urandom));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == PHASE_ITEMS / 2) begin
          // long receiver hold-off while colors keep coming: fill the queue
          hold_request = HOLD_CYCLES;
          for (int k = 0; k < 40; k++) stream(8'($urandom_range(249)), 1'b0);
        end
        if (ph == 2 && n == PHASE_ITEMS / 2) wait_idle();
        random_sequence();
      end
    end

    wait_idle();
    if (runs.mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
